### rtl/sgb_pkg.sv
// sgb_pkg: shared codes and fixed widths of the separable blur block.
// No dependencies; used by sgb_div and separable_gaussian_blur_top.
package sgb_pkg;

    localparam int PIX_W = 8;
    localparam int WGT_W = 16;
    localparam int QUO_W = 16;

    localparam logic [1:0] KIND_WGT_H = 2'd0;
    localparam logic [1:0] KIND_WGT_V = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TAPS_H = 2'd2;
    localparam logic [1:0] CFG_TAPS_V = 2'd3;

endpackage

### rtl/sgb_div.sv
// sgb_div: restoring divider, one quotient bit per cycle.
// Depends on sgb_pkg (quotient width). Quotient must be below 2**QUO_W.
module sgb_div #(
    parameter int NUMW = 48,
    parameter int DENW = 29
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [NUMW-1:0]            num,
    input  logic [DENW-1:0]            den,
    output logic                       done,
    output logic [sgb_pkg::QUO_W-1:0]  quo
);
    localparam int CNTW = $clog2(sgb_pkg::QUO_W + 1);

    logic [NUMW-1:0]           rem_reg, rem_next;
    logic [NUMW-1:0]           dsh_reg, dsh_next;
    logic [sgb_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [CNTW-1:0]           cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num;
            dsh_next  = NUMW'(den) << (sgb_pkg::QUO_W - 1);
            quo_next  = '0;
            cnt_next  = CNTW'(sgb_pkg::QUO_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= dsh_reg) begin
                rem_next = rem_reg - dsh_reg;
                quo_next = {quo_reg[sgb_pkg::QUO_W-2:0], 1'b1};
            end else begin
                quo_next = {quo_reg[sgb_pkg::QUO_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

### rtl/separable_gaussian_blur_top.sv
// Separable blur top: one request is handled at a time; a read request's pixel is read
// from the image store into a register, then registered onto the result stream. After
// the last pixel the blur walks the image store: per output each tap inside the image is
// read, multiplied and accumulated, taps outside are skipped, the sum is divided (zero
// if weights sum to zero), written to the line buffer and copied back. aresetn (sync,
// active low) clears weights, positions and ready flag, sets width/height 256, taps 1.
module separable_gaussian_blur_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_TAPS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // weight_index[3:0], weight_value[19:4], pixel_in[27:20]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // pixel_out[7:0]
    output logic        m_tlast,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LDEPTH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int CW     = $clog2(LDEPTH + 1);
    localparam int TW     = $clog2(MAX_TAPS + 1);
    localparam int TIW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int DW     = TIW + 1;
    localparam int PW     = CW + 2;
    localparam int SW     = $clog2(2 * MAX_TAPS);
    localparam int ACCW   = 32 + SW;
    localparam int NRMW   = 16 + SW;
    localparam int NUMW   = ACCW + 10;
    localparam int DENW   = NRMW + 8;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDW  = 4'd1;
    localparam logic [3:0] S_TAP  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_DIVS = 4'd5;
    localparam logic [3:0] S_DIVW = 4'd6;
    localparam logic [3:0] S_WB   = 4'd7;
    localparam logic [3:0] S_CPR  = 4'd8;
    localparam logic [3:0] S_CPW  = 4'd9;

    // request fields
    logic [1:0]  kind;
    logic [3:0]  weight_index;
    logic [15:0] weight_value;
    logic [7:0]  pixel_in;
    assign kind         = s_tuser[1:0];
    assign weight_index = s_tdata[3:0];
    assign weight_value = s_tdata[19:4];
    assign pixel_in     = s_tdata[27:20];

    // control state
    logic [3:0]    state_reg, state_next;
    logic          pass_col_reg, pass_col_next;
    logic [CW-1:0] o_reg, o_next, n_reg, n_next, cn_reg, cn_next;
    logic signed [DW-1:0] d_reg, d_next;
    logic          ready_reg, ready_next;
    logic [CW-1:0] ld_row_reg, ld_row_next, ld_col_reg, ld_col_next;
    logic [CW-1:0] rd_row_reg, rd_row_next, rd_col_reg, rd_col_next;
    logic          m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic          rlast_reg, rlast_next;
    logic [8:0]    width_reg, width_next, height_reg, height_next;
    logic [4:0]    th_reg, th_next, tv_reg, tv_next;
    logic [15:0]   wh_reg [MAX_TAPS];
    logic [15:0]   wv_reg [MAX_TAPS];
    logic          wh_we, wv_we;

    // datapath
    logic [ACCW-1:0] acc_reg, acc_next;
    logic [NRMW-1:0] nrm_reg, nrm_next;
    logic [15:0]     wsel_reg, wsel_next;
    logic [31:0]     prod_reg, prod_next;
    logic [15:0]     q_reg, q_next;
    logic [7:0]      m_data_reg, m_data_next;

    // memories
    logic [15:0]    img_mem [DEPTH];
    logic           img_we, img_re;
    logic [AW-1:0]  img_waddr, img_raddr;
    logic [15:0]    img_wdata, img_rdata_reg;
    logic [15:0]    lb_mem [LDEPTH];
    logic           lb_we, lb_re;
    logic [LAW-1:0] lb_waddr, lb_raddr;
    logic [15:0]    lb_wdata, lb_rdata_reg;

    // divider
    logic            div_start, div_done;
    logic [NUMW-1:0] div_num;
    logic [DENW-1:0] div_den;
    logic [15:0]     div_quo;

    // effective register values after range clamping
    logic [CW-1:0] eff_w, eff_h;
    logic [TW-1:0] eff_th, eff_tv;

    always_comb begin
        if (width_reg == 9'd0)               eff_w = CW'(1);
        else if (32'(width_reg) > MAX_WIDTH) eff_w = CW'(MAX_WIDTH);
        else                                 eff_w = CW'(width_reg);
        if (height_reg == 9'd0)               eff_h = CW'(1);
        else if (32'(height_reg) > MAX_HEIGHT) eff_h = CW'(MAX_HEIGHT);
        else                                  eff_h = CW'(height_reg);
        if (th_reg == 5'd0)               eff_th = TW'(1);
        else if (32'(th_reg) > MAX_TAPS)  eff_th = TW'(MAX_TAPS);
        else                              eff_th = TW'(th_reg);
        if (tv_reg == 5'd0)               eff_tv = TW'(1);
        else if (32'(tv_reg) > MAX_TAPS)  eff_tv = TW'(MAX_TAPS);
        else                              eff_tv = TW'(tv_reg);
    end

    // current pass: tap range, inner/outer lengths, tap position
    logic signed [DW-1:0] tap_last, d_first, first_h, first_v;
    logic [CW-1:0]        len_in, len_out;
    logic [TIW-1:0]       abs_d;
    logic signed [PW-1:0] tap_pos;
    logic                 tap_in;
    logic [CW-1:0]        pos;
    logic [15:0]          w_sel;
    logic [AW-1:0]        tap_addr, cp_addr, ld_addr, rd_addr;
    logic [15:0]          wb_val;
    logic                 ld_last, rd_last;

    assign first_h  = -DW'(eff_th - TW'(1));
    assign first_v  = -DW'(eff_tv - TW'(1));
    assign tap_last = pass_col_reg ? -first_v : -first_h;
    assign d_first  = pass_col_reg ? first_v : first_h;
    assign len_in   = pass_col_reg ? eff_h : eff_w;
    assign len_out  = pass_col_reg ? eff_w : eff_h;
    assign abs_d    = (d_reg < 0) ? TIW'(-d_reg) : TIW'(d_reg);
    assign tap_pos  = PW'($signed({1'b0, n_reg})) + PW'(d_reg);
    assign tap_in   = (tap_pos >= 0) && (tap_pos < $signed({2'b00, len_in}));
    assign pos      = tap_pos[CW-1:0];
    assign w_sel    = pass_col_reg ? wv_reg[abs_d] : wh_reg[abs_d];
    assign tap_addr = pass_col_reg ? AW'(pos * MAX_WIDTH + o_reg)
                                   : AW'(o_reg * MAX_WIDTH + pos);
    assign cp_addr  = pass_col_reg ? AW'(cn_reg * MAX_WIDTH + o_reg)
                                   : AW'(o_reg * MAX_WIDTH + cn_reg);
    assign ld_addr  = AW'(ld_row_reg * MAX_WIDTH + ld_col_reg);
    assign rd_addr  = AW'(rd_row_reg * MAX_WIDTH + rd_col_reg);
    assign ld_last  = (ld_row_reg == eff_h - CW'(1)) && (ld_col_reg == eff_w - CW'(1));
    assign rd_last  = (rd_row_reg == eff_h - CW'(1)) && (rd_col_reg == eff_w - CW'(1));
    // column pass saturates the final 8-bit value
    assign wb_val   = (pass_col_reg && q_reg > 16'd255) ? 16'd255 : q_reg;

    // divider operands: row pass rounds Q8.8 to nearest, column pass rounds half up
    assign div_num = pass_col_reg ? (NUMW'(acc_reg) + (NUMW'(nrm_reg) << 7))
                                  : ((NUMW'(acc_reg) << 9) + NUMW'(nrm_reg));
    assign div_den = pass_col_reg ? (DENW'(nrm_reg) << 8) : (DENW'(nrm_reg) << 1);

    logic s_acc, cfg_acc, m_acc;
    assign cfg_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign s_tready  = (state_reg == S_IDLE) && !m_valid_reg && !cfg_valid;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign m_acc     = m_valid_reg && m_tready;

    always_comb begin
        state_next    = state_reg;
        pass_col_next = pass_col_reg;
        o_next        = o_reg;
        n_next        = n_reg;
        cn_next       = cn_reg;
        d_next        = d_reg;
        ready_next    = ready_reg;
        ld_row_next   = ld_row_reg;
        ld_col_next   = ld_col_reg;
        rd_row_next   = rd_row_reg;
        rd_col_next   = rd_col_reg;
        m_valid_next  = m_valid_reg && !m_acc;
        m_last_next   = m_last_reg;
        m_data_next   = m_data_reg;
        rlast_next    = rlast_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        th_next       = th_reg;
        tv_next       = tv_reg;
        wh_we         = 1'b0;
        wv_we         = 1'b0;
        acc_next      = acc_reg;
        nrm_next      = nrm_reg;
        wsel_next     = wsel_reg;
        prod_next     = prod_reg;
        q_next        = q_reg;
        img_we        = 1'b0;
        img_waddr     = ld_addr;
        img_wdata     = {8'd0, pixel_in};
        img_re        = 1'b0;
        img_raddr     = tap_addr;
        lb_we         = 1'b0;
        lb_waddr      = n_reg[LAW-1:0];
        lb_wdata      = wb_val;
        lb_re         = 1'b0;
        lb_raddr      = cn_reg[LAW-1:0];
        div_start     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (cfg_acc) begin
                    unique case (cfg_index)
                        sgb_pkg::CFG_WIDTH:  width_next  = cfg_data;
                        sgb_pkg::CFG_HEIGHT: height_next = cfg_data;
                        sgb_pkg::CFG_TAPS_H: th_next     = cfg_data[4:0];
                        sgb_pkg::CFG_TAPS_V: tv_next     = cfg_data[4:0];
                        default: ;
                    endcase
                    ld_row_next = '0;
                    ld_col_next = '0;
                    rd_row_next = '0;
                    rd_col_next = '0;
                    ready_next  = 1'b0;
                end else if (s_acc) begin
                    unique case (kind)
                        sgb_pkg::KIND_WGT_H: wh_we = (32'(weight_index) < MAX_TAPS);
                        sgb_pkg::KIND_WGT_V: wv_we = (32'(weight_index) < MAX_TAPS);
                        sgb_pkg::KIND_PIXEL: begin
                            // a new load drops unread results; read positions are then at zero
                            ready_next  = 1'b0;
                            rd_row_next = '0;
                            rd_col_next = '0;
                            img_we      = 1'b1;
                            if (ld_last) begin
                                ld_row_next   = '0;
                                ld_col_next   = '0;
                                pass_col_next = 1'b0;
                                o_next        = '0;
                                n_next        = '0;
                                d_next        = first_h;
                                acc_next      = '0;
                                nrm_next      = '0;
                                state_next    = S_TAP;
                            end else if (ld_col_reg == eff_w - CW'(1)) begin
                                ld_col_next = '0;
                                ld_row_next = ld_row_reg + CW'(1);
                            end else begin
                                ld_col_next = ld_col_reg + CW'(1);
                            end
                        end
                        sgb_pkg::KIND_READ: begin
                            if (ready_reg) begin
                                img_re     = 1'b1;
                                img_raddr  = rd_addr;
                                rlast_next = rd_last;
                                state_next = S_RDW;
                                if (rd_last) begin
                                    ready_next  = 1'b0;
                                    rd_row_next = '0;
                                    rd_col_next = '0;
                                end else if (rd_col_reg == eff_w - CW'(1)) begin
                                    rd_col_next = '0;
                                    rd_row_next = rd_row_reg + CW'(1);
                                end else begin
                                    rd_col_next = rd_col_reg + CW'(1);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RDW: begin
                m_data_next  = img_rdata_reg[7:0];
                m_valid_next = 1'b1;
                m_last_next  = rlast_reg;
                state_next   = S_IDLE;
            end
            S_TAP: begin
                if (tap_in) begin
                    img_re     = 1'b1;
                    wsel_next  = w_sel;
                    state_next = S_MUL;
                end else if (d_reg == tap_last) begin
                    state_next = S_DIVS;
                end else begin
                    d_next = d_reg + DW'(1);
                end
            end
            S_MUL: begin
                prod_next  = wsel_reg * img_rdata_reg;
                nrm_next   = nrm_reg + NRMW'(wsel_reg);
                state_next = S_ACC;
            end
            S_ACC: begin
                acc_next = acc_reg + ACCW'(prod_reg);
                if (d_reg == tap_last) begin
                    state_next = S_DIVS;
                end else begin
                    d_next     = d_reg + DW'(1);
                    state_next = S_TAP;
                end
            end
            S_DIVS: begin
                if (nrm_reg == '0) begin
                    q_next     = '0;
                    state_next = S_WB;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    q_next     = div_quo;
                    state_next = S_WB;
                end
            end
            S_WB: begin
                lb_we = 1'b1;
                if (n_reg == len_in - CW'(1)) begin
                    cn_next    = '0;
                    state_next = S_CPR;
                end else begin
                    n_next     = n_reg + CW'(1);
                    d_next     = d_first;
                    acc_next   = '0;
                    nrm_next   = '0;
                    state_next = S_TAP;
                end
            end
            S_CPR: begin
                lb_re      = 1'b1;
                state_next = S_CPW;
            end
            S_CPW: begin
                img_we    = 1'b1;
                img_waddr = cp_addr;
                img_wdata = lb_rdata_reg;
                if (cn_reg == len_in - CW'(1)) begin
                    n_next   = '0;
                    acc_next = '0;
                    nrm_next = '0;
                    if (o_reg == len_out - CW'(1)) begin
                        o_next = '0;
                        if (!pass_col_reg) begin
                            pass_col_next = 1'b1;
                            d_next        = first_v;
                            state_next    = S_TAP;
                        end else begin
                            ready_next  = 1'b1;
                            rd_row_next = '0;
                            rd_col_next = '0;
                            state_next  = S_IDLE;
                        end
                    end else begin
                        o_next     = o_reg + CW'(1);
                        d_next     = d_first;
                        state_next = S_TAP;
                    end
                end else begin
                    cn_next    = cn_reg + CW'(1);
                    state_next = S_CPR;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pass_col_reg <= 1'b0;
            o_reg        <= '0;
            n_reg        <= '0;
            cn_reg       <= '0;
            d_reg        <= '0;
            ready_reg    <= 1'b0;
            ld_row_reg   <= '0;
            ld_col_reg   <= '0;
            rd_row_reg   <= '0;
            rd_col_reg   <= '0;
            m_valid_reg  <= 1'b0;
            m_last_reg   <= 1'b0;
            rlast_reg    <= 1'b0;
            width_reg    <= 9'd256;
            height_reg   <= 9'd256;
            th_reg       <= 5'd1;
            tv_reg       <= 5'd1;
            for (int i = 0; i < MAX_TAPS; i++) begin
                wh_reg[i] <= '0;
                wv_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            pass_col_reg <= pass_col_next;
            o_reg        <= o_next;
            n_reg        <= n_next;
            cn_reg       <= cn_next;
            d_reg        <= d_next;
            ready_reg    <= ready_next;
            ld_row_reg   <= ld_row_next;
            ld_col_reg   <= ld_col_next;
            rd_row_reg   <= rd_row_next;
            rd_col_reg   <= rd_col_next;
            m_valid_reg  <= m_valid_next;
            m_last_reg   <= m_last_next;
            rlast_reg    <= rlast_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            th_reg       <= th_next;
            tv_reg       <= tv_next;
            if (wh_we) wh_reg[TIW'(weight_index)] <= weight_value;
            if (wv_we) wv_reg[TIW'(weight_index)] <= weight_value;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        nrm_reg    <= nrm_next;
        wsel_reg   <= wsel_next;
        prod_reg   <= prod_next;
        q_reg      <= q_next;
        m_data_reg <= m_data_next;
    end

    // image store: pixels, then Q8.8 row results, then final pixels
    always_ff @(posedge aclk) begin
        if (img_we) img_mem[img_waddr] <= img_wdata;
        if (img_re) img_rdata_reg <= img_mem[img_raddr];
    end

    // line buffer: one row or one column of results before copy-back
    always_ff @(posedge aclk) begin
        if (lb_we) lb_mem[lb_waddr] <= lb_wdata;
        if (lb_re) lb_rdata_reg <= lb_mem[lb_raddr];
    end

    sgb_div #(
        .NUMW (NUMW),
        .DENW (DENW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // no request is taken while the blur walks the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("request accepted outside idle");

    // divider completes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIVW))
        else $error("divider result with no pending division");

    // handing out the last pixel leaves no results ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_tlast) |-> !ready_reg)
        else $error("results still ready after last pixel");

    // a read result appears only after a read of a ready image
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RDW) |-> $past(ready_reg))
        else $error("read served without ready results");
endmodule
